FILE: rtl/dtfe_pkg.sv
`default_nettype none

package dtfe_pkg;

    localparam logic [11:0] YEAR_MIN   = 12'd1900;
    localparam logic [11:0] YEAR_MAX   = 12'd2099;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [4:0]  DAY_MAX    = 5'd31;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [5:0]  MINUTE_MAX = 6'd59;
    localparam logic [2:0]  NUM_FIELDS = 3'd5;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_LEFT   = 3'd1,
        CMD_RIGHT  = 3'd2,
        CMD_INC    = 3'd3,
        CMD_DEC    = 3'd4,
        CMD_SELECT = 3'd5,
        CMD_APPLY  = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        FLD_YEAR   = 3'd0,
        FLD_MONTH  = 3'd1,
        FLD_DAY    = 3'd2,
        FLD_HOUR   = 3'd3,
        FLD_MINUTE = 3'd4
    } field_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  field_sel;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } item_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        field_t      cursor;
        logic        commit;
    } result_t;

    // Leap when divisible by four, with 1900 as the only exception in range.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic leap;
        leap = (y[1:0] == 2'b00) && (y != YEAR_MIN);
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            4'd2:                    month_len = leap ? 5'd29 : 5'd28;
            default:                 month_len = DAY_MAX;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: rtl/datetime_field_editor.sv
// Each command is held in the input register, then in the result register.
// Throughput: one command per cycle while the output is not stalled; the edit
// is one combinational pass between the input and result registers.
// Reset (rst_n, async, active low): date 1900-01-01, time 00:00, cursor on the
// year field, both pipeline registers empty.
`default_nettype none

module datetime_field_editor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [2:0]  field_sel,
    input  wire logic [11:0] load_year,
    input  wire logic [3:0]  load_month,
    input  wire logic [4:0]  load_day,
    input  wire logic [4:0]  load_hour,
    input  wire logic [5:0]  load_minute,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      year_out,
    output logic [3:0]       month_out,
    output logic [4:0]       day_out,
    output logic [4:0]       hour_out,
    output logic [5:0]       minute_out,
    output logic [2:0]       cursor_out,
    output logic             commit
);

    logic              in_vld_reg;
    dtfe_pkg::item_t   item_reg;
    logic              in_xfer;
    logic              step;
    dtfe_pkg::result_t res;
    dtfe_pkg::result_t out_data;

    // An input transfer lands in the input register. The held command steps
    // the edit state and moves into the result register whenever that register
    // is empty or its result is being transferred out this cycle.
    assign step     = in_vld_reg && (!out_valid || !out_stall);
    assign in_stall = in_vld_reg && !step;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_xfer)
            in_vld_reg <= 1'b1;
        else if (step)
            in_vld_reg <= 1'b0;
    end

    // Payload needs no reset; capture only on a transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.cmd       <= dtfe_pkg::cmd_t'(cmd);
            item_reg.field_sel <= field_sel;
            item_reg.year      <= load_year;
            item_reg.month     <= load_month;
            item_reg.day       <= load_day;
            item_reg.hour      <= load_hour;
            item_reg.minute    <= load_minute;
        end
    end

    // Edit state and the single-pass update of the held command.
    dtfe_edit u_edit (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .res   (res)
    );

    // Result register: holds the post-edit values until the output transfer.
    dtfe_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step),
        .res   (res),
        .stall (out_stall),
        .vld   (out_valid),
        .data  (out_data)
    );

    assign year_out   = out_data.year;
    assign month_out  = out_data.month;
    assign day_out    = out_data.day;
    assign hour_out   = out_data.hour;
    assign minute_out = out_data.minute;
    assign cursor_out = out_data.cursor;
    assign commit     = out_data.commit;

    // The input side backs up only when the result register is full and held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result register can drain");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (year_out >= dtfe_pkg::YEAR_MIN && year_out <= dtfe_pkg::YEAR_MAX))
        else $error("year out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_out >= 4'd1 && month_out <= dtfe_pkg::MONTH_MAX &&
                       day_out != 5'd0))
        else $error("month or day out of range");

    a_time_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour_out <= dtfe_pkg::HOUR_MAX && minute_out <= dtfe_pkg::MINUTE_MAX &&
                       cursor_out < dtfe_pkg::NUM_FIELDS))
        else $error("hour, minute or cursor out of range");

endmodule

`default_nettype wire

FILE: rtl/dtfe_edit.sv
`default_nettype none

module dtfe_edit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire dtfe_pkg::item_t  item,
    output dtfe_pkg::result_t     res
);

    logic [11:0]      year_reg,   year_next;
    logic [3:0]       month_reg,  month_next;
    logic [4:0]       day_reg,    day_next;
    logic [4:0]       hour_reg,   hour_next;
    logic [5:0]       minute_reg, minute_next;
    dtfe_pkg::field_t cursor_reg, cursor_next;
    logic             commit;
    logic [4:0]       len;

    assign len = dtfe_pkg::month_len(month_reg, year_reg);

    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        cursor_next = cursor_reg;
        commit      = 1'b0;
        unique case (item.cmd)
            dtfe_pkg::CMD_LOAD:
            begin
                // saturate every field into its range, keep the cursor
                if (item.year < dtfe_pkg::YEAR_MIN)
                    year_next = dtfe_pkg::YEAR_MIN;
                else if (item.year > dtfe_pkg::YEAR_MAX)
                    year_next = dtfe_pkg::YEAR_MAX;
                else
                    year_next = item.year;
                if (item.month == 4'd0)
                    month_next = 4'd1;
                else if (item.month > dtfe_pkg::MONTH_MAX)
                    month_next = dtfe_pkg::MONTH_MAX;
                else
                    month_next = item.month;
                day_next    = (item.day == 5'd0) ? 5'd1 : item.day;
                hour_next   = (item.hour > dtfe_pkg::HOUR_MAX) ? dtfe_pkg::HOUR_MAX
                                                               : item.hour;
                minute_next = (item.minute > dtfe_pkg::MINUTE_MAX) ? dtfe_pkg::MINUTE_MAX
                                                                   : item.minute;
            end
            dtfe_pkg::CMD_LEFT:
                cursor_next = (cursor_reg == dtfe_pkg::FLD_YEAR) ? dtfe_pkg::FLD_MINUTE
                                                                 : dtfe_pkg::field_t'(cursor_reg - 3'd1);
            dtfe_pkg::CMD_RIGHT:
                cursor_next = (cursor_reg >= dtfe_pkg::FLD_MINUTE) ? dtfe_pkg::FLD_YEAR
                                                                   : dtfe_pkg::field_t'(cursor_reg + 3'd1);
            dtfe_pkg::CMD_INC:
            begin
                unique case (cursor_reg)
                    dtfe_pkg::FLD_YEAR:
                        year_next = (year_reg >= dtfe_pkg::YEAR_MAX) ? dtfe_pkg::YEAR_MIN
                                                                     : year_reg + 12'd1;
                    dtfe_pkg::FLD_MONTH:
                        month_next = (month_reg >= dtfe_pkg::MONTH_MAX) ? 4'd1
                                                                        : month_reg + 4'd1;
                    dtfe_pkg::FLD_DAY:
                        day_next = (day_reg >= len) ? 5'd1 : day_reg + 5'd1;
                    dtfe_pkg::FLD_HOUR:
                        hour_next = (hour_reg >= dtfe_pkg::HOUR_MAX) ? 5'd0 : hour_reg + 5'd1;
                    default:
                        minute_next = (minute_reg >= dtfe_pkg::MINUTE_MAX) ? 6'd0
                                                                           : minute_reg + 6'd1;
                endcase
            end
            dtfe_pkg::CMD_DEC:
            begin
                unique case (cursor_reg)
                    dtfe_pkg::FLD_YEAR:
                        year_next = (year_reg <= dtfe_pkg::YEAR_MIN) ? dtfe_pkg::YEAR_MAX
                                                                     : year_reg - 12'd1;
                    dtfe_pkg::FLD_MONTH:
                        month_next = (month_reg <= 4'd1) ? dtfe_pkg::MONTH_MAX
                                                         : month_reg - 4'd1;
                    dtfe_pkg::FLD_DAY:
                        day_next = (day_reg <= 5'd1) ? len : day_reg - 5'd1;
                    dtfe_pkg::FLD_HOUR:
                        hour_next = (hour_reg == 5'd0) ? dtfe_pkg::HOUR_MAX : hour_reg - 5'd1;
                    default:
                        minute_next = (minute_reg == 6'd0) ? dtfe_pkg::MINUTE_MAX
                                                           : minute_reg - 6'd1;
                endcase
            end
            dtfe_pkg::CMD_SELECT:
            begin
                // drop out-of-range selections
                if (item.field_sel < dtfe_pkg::NUM_FIELDS)
                    cursor_next = dtfe_pkg::field_t'(item.field_sel);
            end
            dtfe_pkg::CMD_APPLY:
                commit = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg   <= dtfe_pkg::YEAR_MIN;
            month_reg  <= 4'd1;
            day_reg    <= 5'd1;
            hour_reg   <= 5'd0;
            minute_reg <= 6'd0;
            cursor_reg <= dtfe_pkg::FLD_YEAR;
        end
        else if (step)
        begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            cursor_reg <= cursor_next;
        end
    end

    assign res.year   = year_next;
    assign res.month  = month_next;
    assign res.day    = day_next;
    assign res.hour   = hour_next;
    assign res.minute = minute_next;
    assign res.cursor = cursor_next;
    assign res.commit = commit;

endmodule

`default_nettype wire

FILE: rtl/dtfe_out_reg.sv
`default_nettype none

module dtfe_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire dtfe_pkg::result_t  res,
    input  wire logic               stall,
    output logic                    vld,
    output dtfe_pkg::result_t       data
);

    logic              vld_reg;
    dtfe_pkg::result_t data_reg;

    // hold the result until its transfer; a load replaces it the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (load)
            vld_reg <= 1'b1;
        else if (!stall)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign vld  = vld_reg;
    assign data = data_reg;

endmodule

`default_nettype wire
